// ===== hdl/utf8qt_pkg.sv =====
// Package: word types, result codes and UTF-8 constants for the quote tokenizer.
`default_nettype none

package utf8qt_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } t_out_word;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_UTF = 2'd1;
    localparam logic [1:0] STAT_UNTERM  = 2'd2;

    // allowed range of the next continuation byte
    localparam logic [2:0] CLS_ANY   = 3'd0;  // 80..BF
    localparam logic [2:0] CLS_A0_BF = 3'd1;
    localparam logic [2:0] CLS_80_9F = 3'd2;
    localparam logic [2:0] CLS_90_BF = 3'd3;
    localparam logic [2:0] CLS_80_8F = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam int RES_MAX    = 3;
    localparam int FIFO_DEPTH = 4;

endpackage

`default_nettype wire

// ===== hdl/utf8_checked_quote_tokenizer.sv =====
// Top level: byte tokenizer with quote handling and strict UTF-8 check.
//
//  channel | valid      | ready       | word
//  --------+------------+-------------+------------
//  input   | i_in_valid | o_in_ready  | i_in_word
//  output  | o_out_valid| i_out_ready | o_out_word
//
// One input word per cycle while o_in_ready is high; each word yields zero to three result words,
// queued in a four-entry result queue and sent one per cycle while i_out_ready is high.
// The input is ready while the queue holds at most one word, so a stream of
// words that each give one result flows at one word per cycle while the output is ready.
// Reset (i_rst_n low, synchronous) clears the tokenizer state and the queue.
// A stall on the output fills the queue and then holds off the input.
`default_nettype none

module utf8_checked_quote_tokenizer (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  utf8qt_pkg::t_in_word   i_in_word,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output utf8qt_pkg::t_out_word  o_out_word
);
    import utf8qt_pkg::*;

    logic       r_inq, r_open, r_bsl, r_bad;
    logic [1:0] r_cont;
    logic [2:0] r_cls;
    logic       n_inq, n_open, n_bsl, n_bad;
    logic [1:0] n_cont;
    logic [2:0] n_cls;

    t_out_word  res [RES_MAX];
    logic [1:0] res_n;

    t_out_word  r_fifo [FIFO_DEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    logic in_acc, out_acc;
    logic [7:0] b;
    logic [7:0] lo, hi;

    assign b           = i_in_word.data_byte;
    assign o_in_ready  = (r_cnt <= 3'(FIFO_DEPTH - RES_MAX));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != 3'd0);
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_out_word  = r_fifo[r_rd];

    always_comb begin
        unique case (r_cls)
            CLS_A0_BF: begin lo = 8'hA0; hi = 8'hBF; end
            CLS_80_9F: begin lo = 8'h80; hi = 8'h9F; end
            CLS_90_BF: begin lo = 8'h90; hi = 8'hBF; end
            CLS_80_8F: begin lo = 8'h80; hi = 8'h8F; end
            default:   begin lo = 8'h80; hi = 8'hBF; end
        endcase
    end

    always_comb begin
        logic [1:0] idx;
        logic       done;
        idx    = 2'd0;
        done   = 1'b0;
        n_inq  = r_inq;
        n_open = r_open;
        n_bsl  = r_bsl;
        n_bad  = r_bad;
        n_cont = r_cont;
        n_cls  = CLS_ANY;
        for (int j = 0; j < RES_MAX; j++) begin
            res[j] = '0;
        end
        if (i_in_word.mode == MODE_END) begin
            if (r_bsl) begin
                res[idx].kind = KIND_BYTE; res[idx].out_byte = CH_BSL; idx = idx + 2'd1;
            end
            if (r_open) begin
                res[idx].kind = KIND_END; idx = idx + 2'd1;
            end
            res[idx].kind = KIND_STATUS;
            if (r_bad || r_cont != 2'd0) res[idx].status = STAT_BAD_UTF;
            else if (r_inq)              res[idx].status = STAT_UNTERM;
            else                         res[idx].status = STAT_OK;
            idx    = idx + 2'd1;
            n_inq  = 1'b0;
            n_open = 1'b0;
            n_bsl  = 1'b0;
            n_bad  = 1'b0;
            n_cont = 2'd0;
        end else begin
            // UTF-8 check
            if (r_cont != 2'd0) begin
                if (b < lo || b > hi) begin
                    n_bad  = 1'b1;
                    n_cont = 2'd0;
                end else begin
                    n_cont = r_cont - 2'd1;
                end
            end else if (b <= 8'h7F) begin
                n_cont = 2'd0;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
                n_cont = 2'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                n_cont = 2'd2;
                if (b == 8'hE0)      n_cls = CLS_A0_BF;
                else if (b == 8'hED) n_cls = CLS_80_9F;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                n_cont = 2'd3;
                if (b == 8'hF0)      n_cls = CLS_90_BF;
                else if (b == 8'hF4) n_cls = CLS_80_8F;
            end else begin
                n_bad = 1'b1;
            end
            // tokenizer
            if (r_bsl) begin
                n_bsl = 1'b0;
                res[idx].kind = KIND_BYTE;
                if (b == CH_QUOTE) begin
                    res[idx].out_byte = CH_QUOTE;
                    done = 1'b1;
                end else begin
                    res[idx].out_byte = CH_BSL;
                end
                idx = idx + 2'd1;
            end
            if (!done) begin
                if (!r_open && b <= CH_SPACE) begin
                    n_open = 1'b0;
                end else begin
                    n_open = 1'b1;
                    if (!r_inq && b <= CH_SPACE) begin
                        res[idx].kind = KIND_END; idx = idx + 2'd1;
                        n_open = 1'b0;
                    end else if (b == CH_QUOTE) begin
                        n_inq = !r_inq;
                    end else if (b == CH_BSL) begin
                        n_bsl = 1'b1;
                    end else begin
                        res[idx].kind = KIND_BYTE; res[idx].out_byte = b;
                        idx = idx + 2'd1;
                    end
                end
            end
        end
        if (idx != 2'd0) res[idx - 2'd1].last = 1'b1;
        res_n = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inq  <= 1'b0;
            r_open <= 1'b0;
            r_bsl  <= 1'b0;
            r_bad  <= 1'b0;
            r_cont <= 2'd0;
            r_cls  <= CLS_ANY;
            r_wr   <= 2'd0;
            r_rd   <= 2'd0;
            r_cnt  <= 3'd0;
        end else begin
            if (in_acc) begin
                r_inq  <= n_inq;
                r_open <= n_open;
                r_bsl  <= n_bsl;
                r_bad  <= n_bad;
                r_cont <= n_cont;
                r_cls  <= n_cls;
                r_wr   <= r_wr + res_n;
            end
            if (out_acc) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + (in_acc ? {1'b0, res_n} : 3'd0) - (out_acc ? 3'd1 : 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int j = 0; j < RES_MAX; j++) begin
                if (2'(j) < res_n) r_fifo[r_wr + 2'(j)] <= res[j];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.mode == MODE_END |=>
            !r_inq && !r_open && !r_bsl && !r_bad && r_cont == 2'd0)
        else $error("state not cleared after end of text");

    a_end_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.mode == MODE_END |-> res_n != 2'd0)
        else $error("end of text without status word");

    a_cont_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cls != CLS_ANY |-> r_cont != 2'd0)
        else $error("continuation range set without pending continuation");

endmodule

`default_nettype wire
